FILE: hdl/lams_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lams_pkg;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_SET    = 2'd2;
  localparam logic [1:0] FUNC_READ   = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EXISTS    = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_MISSING_A = 3'd3;
  localparam logic [2:0] ST_MISSING_B = 3'd4;

  typedef struct packed {
    logic [1:0]         func;
    logic [15:0]        node_a;
    logic [15:0]        node_b;
    logic signed [31:0] weight;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] weight_read;
  } rsp_t;

  typedef struct packed {
    logic wr;
    logic fill;
  } slot_cmd_t;

endpackage

`default_nettype wire

FILE: hdl/lams_slot_table.sv
`timescale 1ns / 1ps
`default_nettype none

module lams_slot_table #(
  parameter int SLOTS = 15,
  parameter int IW    = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [IW-1:0]     rd_idx,
  output logic [15:0]            rd_label,
  output logic                   rd_used,
  input  wire lams_pkg::slot_cmd_t cmd,
  input  wire logic [IW-1:0]     wr_idx,
  input  wire logic [15:0]       wr_label
);
  import lams_pkg::*;

  logic [15:0]      labels [SLOTS];
  logic [SLOTS-1:0] used;

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (cmd.wr) begin
      used[wr_idx] <= cmd.fill;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr && cmd.fill) begin
      labels[wr_idx] <= wr_label;
    end
    rd_label <= labels[rd_idx];
    rd_used  <= used[rd_idx];
  end

endmodule

`default_nettype wire

FILE: hdl/labeled_adjacency_matrix_store.sv
// Labeled adjacency-matrix graph store.
// Request channel: req_valid / req_stall carry one req transaction (func, node_a,
// node_b, weight). Response channel: rsp_valid / rsp_stall return exactly one
// rsp transaction (status, weight_read) per request, in request order.
// Every request first scans the MATRIX_SIZE-1 node slots, one slot per cycle
// through the registered read port of the label table, comparing against both
// labels and noting the first free slot. Remove then frees its slot from
// DECIDE, arc set writes the matrix from ADDR, and arc read passes through
// ADDR, RD1 and RD2 for the registered matrix read. An insert that fills a
// slot clears that slot's row and column of the weight memory, one write per
// cycle, so removal and reset never sweep the matrix.
// One request is worked at a time; req_stall is high until the result has
// been moved into the response register. A result waiting on rsp_stall is
// held there while the next request is accepted and worked.
// Reset empties every slot and drops any pending response.
`timescale 1ns / 1ps
`default_nettype none

module labeled_adjacency_matrix_store #(
  parameter int MATRIX_SIZE = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire lams_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output lams_pkg::rsp_t      rsp
);
  import lams_pkg::*;

  localparam int SLOTS = MATRIX_SIZE - 1;
  localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW    = $clog2(SLOTS + 1);
  localparam int DEPTH = SLOTS * SLOTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [2:0] {
    IDLE, SCAN, DECIDE, CLR, ADDR, RD1, RD2, FINISH
  } state_t;

  state_t state;
  req_t   req_q;

  logic [CW-1:0] cnt;
  logic          pv;
  logic [IW-1:0] ptag;
  logic          phase;

  logic          found_a, found_b, found_free;
  logic [IW-1:0] sa, sb, free_idx;

  logic [2:0]         res_status;
  logic signed [31:0] res_weight;

  slot_cmd_t     slot_cmd;
  logic [IW-1:0] slot_widx;
  logic [15:0]   rd_label;
  logic          rd_used;

  logic [AW-1:0]      maddr;
  logic               mwe;
  logic signed [31:0] mwd;
  logic signed [31:0] arc_mem [DEPTH];
  logic signed [31:0] mem_q;

  logic [IW-1:0] mul_r, mul_c;
  logic [AW-1:0] calc;
  logic          load_rsp;

  lams_slot_table #(
    .SLOTS (SLOTS),
    .IW    (IW)
  ) u_slots (
    .clk      (clk),
    .rst      (rst),
    .rd_idx   (cnt[IW-1:0]),
    .rd_label (rd_label),
    .rd_used  (rd_used),
    .cmd      (slot_cmd),
    .wr_idx   (slot_widx),
    .wr_label (req_q.node_a)
  );

  // shared row * SLOTS + column unit
  always_comb begin
    mul_r = sa;
    mul_c = sb;
    if (state == CLR) begin
      if (phase) begin
        mul_r = cnt[IW-1:0];
        mul_c = slot_widx;
      end else begin
        mul_r = slot_widx;
        mul_c = cnt[IW-1:0];
      end
    end
    calc = AW'(mul_r) * AW'(SLOTS) + AW'(mul_c);
  end

  always_ff @(posedge clk) begin
    if (mwe) begin
      arc_mem[maddr] <= mwd;
    end
    mem_q <= arc_mem[maddr];
  end

  assign req_stall = (state != IDLE);
  assign load_rsp  = (state == FINISH) && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      rsp_valid <= 1'b0;
      mwe       <= 1'b0;
      slot_cmd  <= '0;
      pv        <= 1'b0;
    end else begin
      mwe      <= 1'b0;
      slot_cmd <= '0;
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (req_valid) begin
            req_q      <= req;
            cnt        <= '0;
            pv         <= 1'b0;
            phase      <= 1'b0;
            found_a    <= 1'b0;
            found_b    <= 1'b0;
            found_free <= 1'b0;
            res_weight <= '0;
            state      <= SCAN;
          end
        end
        SCAN: begin
          if (pv) begin
            if (rd_used && rd_label == req_q.node_a && !found_a) begin
              found_a <= 1'b1;
              sa      <= ptag;
            end
            if (rd_used && rd_label == req_q.node_b && !found_b) begin
              found_b <= 1'b1;
              sb      <= ptag;
            end
            if (!rd_used && !found_free) begin
              found_free <= 1'b1;
              free_idx   <= ptag;
            end
          end
          pv   <= (cnt < CW'(SLOTS));
          ptag <= cnt[IW-1:0];
          if (cnt < CW'(SLOTS)) begin
            cnt <= cnt + CW'(1);
          end else if (!pv) begin
            state <= DECIDE;
          end
        end
        DECIDE: begin
          res_status <= ST_OK;
          state      <= FINISH;
          unique case (req_q.func)
            FUNC_INSERT: begin
              if (req_q.node_a == 16'd0 || found_a) begin
                res_status <= ST_EXISTS;
              end else if (!found_free) begin
                res_status <= ST_FULL;
              end else begin
                slot_cmd  <= '{wr: 1'b1, fill: 1'b1};
                slot_widx <= free_idx;
                cnt       <= '0;
                state     <= CLR;
              end
            end
            FUNC_REMOVE: begin
              if (!found_a) begin
                res_status <= ST_MISSING_A;
              end else begin
                slot_cmd  <= '{wr: 1'b1, fill: 1'b0};
                slot_widx <= sa;
              end
            end
            default: begin
              if (!found_a) begin
                res_status <= ST_MISSING_A;
              end else if (!found_b) begin
                res_status <= ST_MISSING_B;
              end else begin
                state <= ADDR;
              end
            end
          endcase
        end
        CLR: begin
          maddr <= calc;
          mwd   <= '0;
          mwe   <= 1'b1;
          if (cnt == CW'(SLOTS - 1)) begin
            cnt <= '0;
            if (phase) begin
              state <= FINISH;
            end else begin
              phase <= 1'b1;
            end
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        ADDR: begin
          maddr <= calc;
          if (req_q.func == FUNC_SET) begin
            mwd   <= req_q.weight;
            mwe   <= 1'b1;
            state <= FINISH;
          end else begin
            state <= RD1;
          end
        end
        RD1: begin
          state <= RD2;
        end
        RD2: begin
          res_weight <= mem_q;
          state      <= FINISH;
        end
        FINISH: begin
          if (load_rsp) begin
            rsp_valid <= 1'b1;
            state     <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp.status      <= res_status;
      rsp.weight_read <= res_weight;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request accepted while idle did not start work");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.status <= ST_MISSING_B)
    else $error("response status out of range");

  a_error_zero_weight: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.weight_read == 32'sd0)
    else $error("failed request returned a nonzero weight");

  a_addr_range: assert property (@(posedge clk) disable iff (rst)
    mwe |-> {1'b0, maddr} < (AW + 1)'(DEPTH))
    else $error("matrix write beyond the last entry");

endmodule

`default_nettype wire
